>>> hw/rtl/slac_pkg.sv
// Shared types and constants for the set-associative LRU tag store.
// Line layout, configuration register indexes and controller states.
// No dependencies; imported by slac_victim, set_assoc_lru_cache_model and the testbench.
package slac_pkg;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int OUT_WAY_W = 3;

    // One line in a set row: {valid, tag, stamp}
    localparam int LINE_W    = 1 + TAG_W + STAMP_W;
    localparam int VALID_BIT = TAG_W + STAMP_W;
    localparam int TAG_LSB   = STAMP_W;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [STAMP_W-1:0]   stamp_t;

    localparam cfg_idx_t CFG_OFFSET_BITS    = 2'd0;
    localparam cfg_idx_t CFG_SET_INDEX_BITS = 2'd1;
    localparam cfg_idx_t CFG_WAYS_USED      = 2'd2;

    localparam cfg_val_t OFFSET_BITS_RST    = 4'd4;
    localparam cfg_val_t SET_INDEX_BITS_RST = 4'd6;
    localparam cfg_val_t WAYS_USED_RST      = 4'd8;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

endpackage

>>> hw/rtl/slac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of the address being written returns the old contents.
// No dependencies.
module slac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/slac_victim.sv
// LRU victim picker: compare tree over per-way ages, oldest enabled way wins,
// lowest way on equal ages. Depends on slac_pkg.
module slac_victim #(
    parameter int N_WAYS = 8,
    parameter int WAY_W  = 3
) (
    input  slac_pkg::stamp_t [N_WAYS-1:0] ages,
    input  logic [N_WAYS-1:0]             way_en,
    output logic [WAY_W-1:0]              victim
);

    import slac_pkg::*;

    localparam int LEAVES = 1 << $clog2(N_WAYS);
    localparam int NODES  = 2 * LEAVES - 1;

    stamp_t           node_age [NODES];
    logic             node_en  [NODES];
    logic [WAY_W-1:0] node_idx [NODES];

    // Leaves, padded with disabled entries up to a power of two
    for (genvar l = 0; l < LEAVES; l++)
    begin : g_leaf
        if (l < N_WAYS)
        begin : g_used
            assign node_age[LEAVES-1+l] = ages[l];
            assign node_en[LEAVES-1+l]  = way_en[l];
            assign node_idx[LEAVES-1+l] = WAY_W'(l);
        end
        else
        begin : g_pad
            assign node_age[LEAVES-1+l] = '0;
            assign node_en[LEAVES-1+l]  = 1'b0;
            assign node_idx[LEAVES-1+l] = '0;
        end
    end

    // Inner nodes: left child holds lower ways, so it wins ties
    for (genvar n = 0; n < LEAVES - 1; n++)
    begin : g_node
        logic take_left;
        assign take_left = node_en[2*n+1] &&
                           (!node_en[2*n+2] || node_age[2*n+1] >= node_age[2*n+2]);
        assign node_age[n] = take_left ? node_age[2*n+1] : node_age[2*n+2];
        assign node_en[n]  = node_en[2*n+1] || node_en[2*n+2];
        assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
    end

    assign victim = node_idx[0];

endmodule

>>> hw/rtl/set_assoc_lru_cache_model.sv
// Set-associative tag store with true-LRU replacement, one set row per RAM word.
// Each item passes the set RAM read, the compare state and the update state before its result strobe is registered.
// A new item can be accepted in the update state while the last one is written back to the set RAM.
// After reset a clearing pass zeroes every row of the set RAM; busy stays high meanwhile.
// Results are strobed for one cycle and cannot be stalled.
// Depends on slac_pkg, slac_ram and slac_victim.
module set_assoc_lru_cache_model #(
    parameter int MAX_WAYS = 8,
    parameter int MAX_SETS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [slac_pkg::ADDR_W-1:0]  address,
    input  logic                         cfg_we,
    input  slac_pkg::cfg_idx_t           cfg_index,
    input  slac_pkg::cfg_val_t           cfg_data,
    output logic                         strobe,
    output logic                         hit,
    output logic [slac_pkg::OUT_WAY_W-1:0] way,
    output logic                         evicted,
    output logic [slac_pkg::CNT_W-1:0]   access_count,
    output logic [slac_pkg::CNT_W-1:0]   hit_count
);

    import slac_pkg::*;

    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_BITS0 = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_BITS  = (SET_BITS0 > 16) ? 16 : SET_BITS0;
    localparam int ROW_W     = MAX_WAYS * LINE_W;
    localparam logic [4:0] SET_BITS_L = 5'(SET_BITS);
    localparam logic [4:0] MAX_WAYS_L = 5'(MAX_WAYS);
    localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(MAX_SETS - 1);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    cfg_val_t offset_bits_reg,    offset_bits_next;
    cfg_val_t set_index_bits_reg, set_index_bits_next;
    cfg_val_t ways_used_reg,      ways_used_next;

    logic [SET_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;

    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [SET_AW-1:0] set_reg, set_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    stamp_t [MAX_WAYS-1:0] ages_reg, ages_next;
    logic [MAX_WAYS-1:0] hit_vec_reg, hit_vec_next;
    logic [MAX_WAYS-1:0] inv_vec_reg, inv_vec_next;

    logic              fwd_hit_reg, fwd_hit_next;
    logic [ROW_W-1:0]  fwd_row_reg, fwd_row_next;

    logic              strobe_reg, strobe_next;
    logic              hit_out_reg, hit_out_next;
    logic [OUT_WAY_W-1:0] way_out_reg, way_out_next;
    logic              evicted_reg, evicted_next;
    logic [CNT_W-1:0]  acc_out_reg, acc_out_next;

    logic              accept;
    logic [3:0]        sb_eff;
    logic [4:0]        nw_eff;
    logic [MAX_WAYS-1:0] way_en;
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] set_full;
    logic [SET_AW-1:0] rd_set;
    logic [TAG_W-1:0]  tag_new;

    logic              ram_we;
    logic [SET_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_cur;

    logic              hit_any;
    logic              inv_any;
    logic [WAY_W-1:0]  hit_idx;
    logic [WAY_W-1:0]  inv_idx;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  sel;
    logic [ROW_W-1:0]  upd_row;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_comb
    begin
        offset_bits_next    = offset_bits_reg;
        set_index_bits_next = set_index_bits_reg;
        ways_used_next      = ways_used_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS:    offset_bits_next    = cfg_data;
                CFG_SET_INDEX_BITS: set_index_bits_next = cfg_data;
                CFG_WAYS_USED:      ways_used_next      = cfg_data;
                default:            ;
            endcase
        end
    end

    // Effective geometry: set bits and ways saturate to what is built; zero ways counts as one
    assign sb_eff = ({1'b0, set_index_bits_reg} < SET_BITS_L) ? set_index_bits_reg
                                                             : SET_BITS_L[3:0];

    always_comb
    begin
        priority if (ways_used_reg == '0)
            nw_eff = 5'd1;
        else if ({1'b0, ways_used_reg} > MAX_WAYS_L)
            nw_eff = MAX_WAYS_L;
        else
            nw_eff = {1'b0, ways_used_reg};
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_en[w] = 5'(w) < nw_eff;
        end
    end

    // ------------------------------------------------------------------
    // Address split at accept
    // ------------------------------------------------------------------
    assign accept   = start && !busy;
    assign block    = address >> offset_bits_reg;
    assign set_full = block & ((32'd1 << sb_eff) - 32'd1);
    assign rd_set   = set_full[SET_AW-1:0];
    assign tag_new  = block >> sb_eff;

    // ------------------------------------------------------------------
    // Set RAM
    // ------------------------------------------------------------------
    slac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_set),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_idx_reg == LAST_SET) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_CMP;
            ST_CMP:   state_next = ST_UPD;
            ST_UPD:   state_next = start ? ST_CMP : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshake and RAM write port
    // ------------------------------------------------------------------
    always_comb
    begin
        busy      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = upd_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                busy      = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            ST_IDLE: ;
            ST_CMP:  busy = 1'b1;
            ST_UPD:  ram_we = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Compare stage: forward a row written at the accepting edge
    // ------------------------------------------------------------------
    assign row_cur = fwd_hit_reg ? fwd_row_reg : ram_rdata;

    always_comb
    begin
        logic [LINE_W-1:0] line;
        line         = '0;
        hit_vec_next = hit_vec_reg;
        inv_vec_next = inv_vec_reg;
        ages_next    = ages_reg;
        row_next     = row_reg;
        if (state_reg == ST_CMP)
        begin
            row_next = row_cur;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                line            = row_cur[w*LINE_W +: LINE_W];
                hit_vec_next[w] = way_en[w] && line[VALID_BIT] &&
                                  (line[TAG_LSB +: TAG_W] == tag_reg);
                inv_vec_next[w] = way_en[w] && !line[VALID_BIT];
                ages_next[w]    = acc_cnt_reg - line[0 +: STAMP_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Update stage: choose the way and build the row to write back
    // ------------------------------------------------------------------
    slac_victim #(
        .N_WAYS (MAX_WAYS),
        .WAY_W  (WAY_W)
    ) u_victim (
        .ages   (ages_reg),
        .way_en (way_en),
        .victim (victim)
    );

    assign hit_any = |hit_vec_reg;
    assign inv_any = |inv_vec_reg;

    // Lowest set bit of each vector
    always_comb
    begin
        hit_idx = '0;
        inv_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec_reg[w]) hit_idx = WAY_W'(w);
            if (inv_vec_reg[w]) inv_idx = WAY_W'(w);
        end
    end

    always_comb
    begin
        priority if (hit_any)
            sel = hit_idx;
        else if (inv_any)
            sel = inv_idx;
        else
            sel = victim;
    end

    always_comb
    begin
        upd_row = row_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_W'(w) == sel)
            begin
                upd_row[w*LINE_W +: STAMP_W] = acc_cnt_reg;
                if (!hit_any)
                begin
                    upd_row[w*LINE_W + TAG_LSB +: TAG_W] = tag_reg;
                    upd_row[w*LINE_W + VALID_BIT]        = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item registers, counters, forwarding and results
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_idx_next = (state_reg == ST_CLEAR) ? clr_idx_reg + 1'b1 : clr_idx_reg;
        acc_cnt_next = accept ? acc_cnt_reg + 1'b1 : acc_cnt_reg;
        hit_cnt_next = (state_reg == ST_UPD && hit_any) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
        tag_next     = accept ? tag_new : tag_reg;
        set_next     = accept ? rd_set  : set_reg;

        fwd_hit_next = accept && (state_reg == ST_UPD) && (rd_set == set_reg);
        fwd_row_next = (state_reg == ST_UPD) ? upd_row : fwd_row_reg;

        strobe_next  = (state_reg == ST_UPD);
        hit_out_next = hit_out_reg;
        way_out_next = way_out_reg;
        evicted_next = evicted_reg;
        acc_out_next = acc_out_reg;
        if (state_reg == ST_UPD)
        begin
            hit_out_next = hit_any;
            way_out_next = OUT_WAY_W'(sel);
            evicted_next = !hit_any && !inv_any;
            acc_out_next = acc_cnt_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            offset_bits_reg    <= OFFSET_BITS_RST;
            set_index_bits_reg <= SET_INDEX_BITS_RST;
            ways_used_reg      <= WAYS_USED_RST;
            clr_idx_reg        <= '0;
            acc_cnt_reg        <= '0;
            hit_cnt_reg        <= '0;
            fwd_hit_reg        <= 1'b0;
            strobe_reg         <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            offset_bits_reg    <= offset_bits_next;
            set_index_bits_reg <= set_index_bits_next;
            ways_used_reg      <= ways_used_next;
            clr_idx_reg        <= clr_idx_next;
            acc_cnt_reg        <= acc_cnt_next;
            hit_cnt_reg        <= hit_cnt_next;
            fwd_hit_reg        <= fwd_hit_next;
            strobe_reg         <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        set_reg     <= set_next;
        row_reg     <= row_next;
        ages_reg    <= ages_next;
        hit_vec_reg <= hit_vec_next;
        inv_vec_reg <= inv_vec_next;
        fwd_row_reg <= fwd_row_next;
        hit_out_reg <= hit_out_next;
        way_out_reg <= way_out_next;
        evicted_reg <= evicted_next;
        acc_out_reg <= acc_out_next;
    end

    assign strobe       = strobe_reg;
    assign hit          = hit_out_reg;
    assign way          = way_out_reg;
    assign evicted      = evicted_reg;
    assign access_count = acc_out_reg;
    assign hit_count    = hit_cnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_UPD))
        else $error("result strobe without an update cycle");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held for more than one cycle");

    a_fwd_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> state_reg == ST_CMP)
        else $error("forwarded row outside the compare cycle");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(hit && evicted))
        else $error("item reported as both hit and eviction");

endmodule

>>> test/testbench.sv
// Self-checking bench for set_assoc_lru_cache_model: directed table, then random traces.
// Holds its own tag-store predictor with true-LRU choice and a queue of expected lookups.
// Depends on slac_pkg and the RTL of set_assoc_lru_cache_model.
`timescale 1ns / 1ps

module testbench;
    import slac_pkg::*;

    localparam int MAX_WAYS     = 8;
    localparam int MAX_SETS     = 1024;
    localparam int LINES        = MAX_SETS * MAX_WAYS;
    localparam int SET_BITS_CAP = $clog2(MAX_SETS);
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 80;
    localparam int POOL_DEPTH   = 24;

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic                 evicted;
        logic [CNT_W-1:0]     accesses;
        logic [CNT_W-1:0]     hits;
    } lookup_result_t;

    typedef enum logic { ROW_ACCESS, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cfg_idx_t          reg_idx;
        cfg_val_t          reg_val;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        lookup_result_t    want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 26;

    // Reset geometry: 16-byte blocks, 64 sets, 8 ways
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // cold miss, then hit in the same block, far corner of the address space
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0000, 1'b1,
          '{1'b0, 3'd0, 1'b0, 32'd1, 32'd0}},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_000F, 1'b1,
          '{1'b1, 3'd0, 1'b0, 32'd2, 32'd1}},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 3'd0, 1'b0, 32'd3, 32'd1}},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0000, 1'b1,
          '{1'b1, 3'd0, 1'b0, 32'd4, 32'd2}},
        // fill the rest of set 0, then force two LRU evictions
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0400, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0800, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0C00, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_1000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_1400, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_1800, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_1C00, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_2000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0000, 1'b0, '0},
        // zero ways behaves as direct mapped
        '{ROW_WRITE,  CFG_WAYS_USED,   4'd0, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_4000, 1'b0, '0},
        // oversized way count saturates
        '{ROW_WRITE,  CFG_WAYS_USED,   4'd15, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_4000, 1'b0, '0},
        // oversized set count saturates
        '{ROW_WRITE,  CFG_SET_INDEX_BITS, 4'd15, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'hFFFF_FFF0, 1'b0, '0},
        // widest block
        '{ROW_WRITE,  CFG_OFFSET_BITS, 4'd15, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'hFFFF_8000, 1'b0, '0},
        // byte blocks, one set: old lines looked up under the new geometry
        '{ROW_WRITE,  CFG_OFFSET_BITS, 4'd0, 32'h0000_0000, 1'b0, '0},
        '{ROW_WRITE,  CFG_SET_INDEX_BITS, 4'd0, 32'h0000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h8000_0000, 1'b0, '0},
        '{ROW_ACCESS, CFG_OFFSET_BITS, 4'd0, 32'h0000_0001, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [ADDR_W-1:0] address;
    logic              cfg_we;
    cfg_idx_t          cfg_index;
    cfg_val_t          cfg_data;
    logic              strobe;
    logic              hit;
    logic [OUT_WAY_W-1:0] way;
    logic              evicted;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  hit_count;

    // Shadow tag store and geometry
    cfg_val_t      offset_reg = OFFSET_BITS_RST;
    cfg_val_t      sets_reg   = SET_INDEX_BITS_RST;
    cfg_val_t      ways_reg   = WAYS_USED_RST;
    bit            shadow_valid [LINES];
    logic [31:0]   shadow_tag   [LINES];
    stamp_t        shadow_stamp [LINES];
    logic [31:0]   accesses_seen = '0;
    logic [31:0]   hits_seen     = '0;

    lookup_result_t    pending_lookups [$];
    logic [ADDR_W-1:0] recent_addrs [$];
    int unsigned       error_count = 0;
    bit                no_gaps = 1'b0;

    set_assoc_lru_cache_model #(
        .MAX_WAYS (MAX_WAYS),
        .MAX_SETS (MAX_SETS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .address      (address),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .hit          (hit),
        .way          (way),
        .evicted      (evicted),
        .access_count (access_count),
        .hit_count    (hit_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned used_set_bits();
        return (sets_reg > SET_BITS_CAP) ? SET_BITS_CAP : sets_reg;
    endfunction

    function automatic int unsigned used_ways();
        if (ways_reg == 0)
            return 1;
        return (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
    endfunction

    // Look up one address in the shadow store and update it
    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] a);
        int unsigned    sb;
        int unsigned    nw;
        int unsigned    base;
        int unsigned    sel;
        int unsigned    w;
        logic [31:0]    blk;
        logic [31:0]    tag;
        logic [31:0]    age;
        logic [31:0]    oldest;
        logic           matched;
        logic           filled;
        lookup_result_t r;
        sb      = used_set_bits();
        nw      = used_ways();
        blk     = a >> offset_reg;
        base    = (blk & ((32'd1 << sb) - 32'd1)) * MAX_WAYS;
        tag     = blk >> sb;
        matched = 1'b0;
        filled  = 1'b0;
        sel     = 0;
        oldest  = '0;
        accesses_seen = accesses_seen + 32'd1;

        for (w = 0; w < nw && !matched; w++)
            if (shadow_valid[base + w] && shadow_tag[base + w] == tag)
            begin
                matched = 1'b1;
                sel     = w;
            end

        if (!matched)
        begin
            for (w = 0; w < nw && !filled; w++)
                if (!shadow_valid[base + w])
                begin
                    filled = 1'b1;
                    sel    = w;
                end
            // oldest stamp wins, lowest way on a tie
            if (!filled)
                for (w = 0; w < nw; w++)
                begin
                    age = accesses_seen - shadow_stamp[base + w];
                    if (w == 0 || age > oldest)
                    begin
                        oldest = age;
                        sel    = w;
                    end
                end
            shadow_tag[base + sel]   = tag;
            shadow_valid[base + sel] = 1'b1;
        end
        else
            hits_seen = hits_seen + 32'd1;
        shadow_stamp[base + sel] = accesses_seen;

        r.hit      = matched;
        r.way      = OUT_WAY_W'(sel);
        r.evicted  = !matched && !filled;
        r.accesses = accesses_seen;
        r.hits     = hits_seen;
        return r;
    endfunction

    // Mostly reuse and hot-set conflicts, some fully random addresses
    function automatic logic [ADDR_W-1:0] next_address();
        int unsigned pick;
        logic [31:0] blk;
        logic [31:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 45 && recent_addrs.size() != 0)
            a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        else if (pick < 85)
        begin
            blk = (32'($urandom_range(0, used_ways() + 3)) << used_set_bits())
                | (32'($urandom_range(0, 3)) & ((32'd1 << used_set_bits()) - 32'd1));
            a = (blk << offset_reg) | ($urandom & ((32'd1 << offset_reg) - 32'd1));
        end
        else
            a = $urandom;
        recent_addrs.push_back(a);
        if (recent_addrs.size() > POOL_DEPTH)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    function automatic cfg_val_t pick_setting(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return cfg_val_t'($urandom_range(lo, hi));
        endcase
    endfunction

    // Register write; the enable is dropped by the next lookup
    task automatic program_register(input cfg_idx_t idx, input cfg_val_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_OFFSET_BITS:    offset_reg = val;
            CFG_SET_INDEX_BITS: sets_reg   = val;
            CFG_WAYS_USED:      ways_reg   = val;
            default:            ;
        endcase
        @(posedge clk);
    endtask

    // Present one address, with random gaps unless no_gaps is set, and record its expected result
    task automatic issue_access(input logic [ADDR_W-1:0] a, input logic typed,
                                input lookup_result_t want);
        lookup_result_t predicted;
        cfg_we <= 1'b0;
        if (!no_gaps)
            while ($urandom_range(0, 99) < 36)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start   <= 1'b1;
        address <= a;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_lookup(a);
        pending_lookups.push_back(typed ? want : predicted);
    endtask

    // Let every outstanding lookup come back and the block go idle
    task automatic settle_block();
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // Results cannot be held off: check every strobe against the oldest expectation
    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got hit=%0b way=%0d",
                         $realtime, hit, way);
                error_count++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                compare_field("hit", 32'(want.hit), 32'(hit));
                compare_field("way", 32'(want.way), 32'(way));
                compare_field("evicted", 32'(want.evicted), 32'(evicted));
                compare_field("access_count", want.accesses, access_count);
                compare_field("hit_count", want.hits, hit_count);
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned n;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        address   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // clearing pass
        while (busy)
            @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle_block();
                program_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                issue_access(directed_rows[i].addr, directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // Random traces, a fresh geometry per phase; one phase runs back to back
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            program_register(CFG_OFFSET_BITS, pick_setting(0, 8));
            program_register(CFG_SET_INDEX_BITS, pick_setting(0, 10));
            program_register(CFG_WAYS_USED, pick_setting(1, 8));
            no_gaps = (phase == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
                issue_access(next_address(), 1'b0, '0);
        end

        settle_block();
        if (error_count == 0 && pending_lookups.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
